// File: design/bbl_pkg.sv
// shared constants, types and the rounding average for the 3x3x3 box blur
package bbl_pkg;

	localparam int MAX_SIZE_X = 64;
	localparam int MAX_SIZE_Y = 64;

	localparam int SW  = 7;                          // size_x / size_y register width
	localparam int SZW = 11;                         // size_z register width
	localparam int XW  = $clog2(MAX_SIZE_X);
	localparam int YW  = $clog2(MAX_SIZE_Y);
	localparam int CXW = $clog2(MAX_SIZE_X + 1);
	localparam int CYW = $clog2(MAX_SIZE_Y + 1);
	localparam int PW  = XW + YW;

	localparam int LINE_DEPTH  = 2 ** XW;
	localparam int PLANE_DEPTH = 2 ** PW;
	localparam int PAIR_W      = 32;

	localparam int QDEPTH    = 4;
	localparam int QPW       = $clog2(QDEPTH);
	localparam int QCW       = $clog2(QDEPTH + 1);
	localparam int OUT_DEPTH = 4;
	localparam int OPW       = $clog2(OUT_DEPTH);
	localparam int OCW       = $clog2(OUT_DEPTH + 1);

	localparam int PAW = 4;

	// 2^19 / 3 rounded up, exact for sums below 2^19
	localparam logic [17:0] RECIP3 = 18'd174763;

	typedef enum logic [1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CXW-1:0] cx;
		logic [CYW-1:0] cy;
		logic [SZW-1:0] cz;
	} dims_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic [15:0]   xv;
		logic [XW-1:0] laddr;
		logic          top_ok;
		logic          bot_ok;
		logic          s_on;
		logic [PW-1:0] paddr;
		logic          front_ok;
		logic          back_ok;
		logic          t_on;
		logic          last;
	} desc_t;

	typedef struct packed {
		logic [15:0] smoothed;
		logic        last;
	} out_t;

	function automatic logic [15:0] avg3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		logic [17:0] s;
		logic [35:0] p;
		s = {2'b00, a} + {2'b00, b} + {2'b00, c} + 18'd1;
		p = s * RECIP3;
		return p[34:19];
	endfunction

endpackage

// File: design/bbl_ifs.sv
// valid/ready stream interfaces for voxel samples and filtered results
interface bbl_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] sample;

	modport source (output valid, output cmd, output sample, input ready);
	modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface bbl_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] smoothed;
	logic        last;

	modport source (output valid, output smoothed, output last, input ready);
	modport sink (input valid, input smoothed, input last, output ready);
endinterface

// File: design/bbl_ram.sv
// generic simple dual port ram, registered read, read returns old data
module bbl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: design/bbl_front.sv
// front: accepts samples, tracks raster positions, does the x pass, classifies items
module bbl_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           restart,
	input  bbl_pkg::dims_t dims,
	bbl_in_if.sink         samples,
	input  logic           full,
	output logic           push,
	output bbl_pkg::desc_t desc
);
	import bbl_pkg::*;

	logic [15:0]    row0_q, row1_q;
	logic           q_on_q, in_done_q;
	logic [XW-1:0]  qx_q, xr_q;
	logic [YW-1:0]  qy_q, ys_q;
	logic [SZW-1:0] qz_q, zt_q;
	logic           s_on_q, t_on_q;

	logic           accept, finish;
	logic [15:0]    vin, left, right;
	logic           x_end, y_end, z_end, qx_end, qy_end, qz_end;

	always_comb begin
		samples.ready = !full;
		accept = samples.valid && !full;
		vin    = (!samples.cmd && !in_done_q) ? samples.sample : 16'd0;

		x_end  = CXW'(xr_q) == dims.cx - CXW'(1);
		y_end  = CYW'(ys_q) == dims.cy - CYW'(1);
		z_end  = zt_q == dims.cz - SZW'(1);
		qx_end = CXW'(qx_q) == dims.cx - CXW'(1);
		qy_end = CYW'(qy_q) == dims.cy - CYW'(1);
		qz_end = qz_q == dims.cz - SZW'(1);

		left  = (xr_q == '0) ? 16'd0 : row1_q;
		right = x_end ? 16'd0 : vin;

		desc.xv       = avg3(left, row0_q, right);
		desc.laddr    = xr_q;
		desc.top_ok   = ys_q != '0;
		desc.bot_ok   = !y_end;
		desc.s_on     = s_on_q;
		desc.paddr    = {ys_q, xr_q};
		desc.front_ok = zt_q != '0;
		desc.back_ok  = !z_end;
		desc.t_on     = t_on_q;
		desc.last     = t_on_q && z_end && y_end && x_end;

		finish = q_on_q && desc.last;
		push   = accept && q_on_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q    <= '0;
			row1_q    <= '0;
			q_on_q    <= 1'b0;
			in_done_q <= 1'b0;
			qx_q      <= '0;
			qy_q      <= '0;
			qz_q      <= '0;
			xr_q      <= '0;
			ys_q      <= '0;
			zt_q      <= '0;
			s_on_q    <= 1'b0;
			t_on_q    <= 1'b0;
		end else if (restart || (accept && finish)) begin
			row0_q    <= '0;
			row1_q    <= '0;
			q_on_q    <= 1'b0;
			in_done_q <= 1'b0;
			qx_q      <= '0;
			qy_q      <= '0;
			qz_q      <= '0;
			xr_q      <= '0;
			ys_q      <= '0;
			zt_q      <= '0;
			s_on_q    <= 1'b0;
			t_on_q    <= 1'b0;
		end else if (accept) begin
			row1_q <= row0_q;
			row0_q <= vin;
			q_on_q <= 1'b1;
			if (!in_done_q) begin
				if (qx_end) begin
					qx_q <= '0;
					if (qy_end) begin
						qy_q <= '0;
						if (qz_end) begin
							in_done_q <= 1'b1;
						end else begin
							qz_q <= qz_q + SZW'(1);
						end
					end else begin
						qy_q <= qy_q + YW'(1);
					end
				end else begin
					qx_q <= qx_q + XW'(1);
				end
			end
			if (q_on_q) begin
				if (x_end) begin
					xr_q <= '0;
					if (s_on_q) begin
						if (y_end) begin
							ys_q <= '0;
							if (t_on_q) begin
								zt_q <= zt_q + SZW'(1);
							end else begin
								t_on_q <= 1'b1;
							end
						end else begin
							ys_q <= ys_q + YW'(1);
						end
					end else begin
						s_on_q <= 1'b1;
					end
				end else begin
					xr_q <= xr_q + XW'(1);
				end
			end
		end
	end
endmodule

// File: design/bbl_queue.sv
// short queue of classified items between front and back
module bbl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bbl_pkg::desc_t din,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output bbl_pkg::desc_t head
);
	import bbl_pkg::*;

	desc_t          mem_q [QDEPTH];
	logic [QPW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;

	assign full  = cnt_q == QCW'(QDEPTH);
	assign valid = cnt_q != '0;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QPW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// File: design/bbl_back.sv
// back: y pass over the line store, z pass over the plane store, result buffer
module bbl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  bbl_pkg::desc_t head,
	output logic           pop,
	bbl_out_if.source      results
);
	import bbl_pkg::*;

	// stage 1: line word back from ram
	logic                v1_q;
	desc_t               d1_q;
	logic                lhit1_q;
	logic [PAIR_W-1:0]   lbyp1_q;
	// stage 2: plane word back from ram
	logic                v2_q;
	desc_t               d2_q;
	logic [15:0]         yv2_q;
	logic                phit2_q;
	logic [PAIR_W-1:0]   pbyp2_q;

	logic [PAIR_W-1:0]   lrd, prd, lword, pword, lwdata, pwdata;
	logic                lwe, pwe, pre;
	logic [15:0]         yv, zv, top, midz, frnt;

	out_t                ofifo_q [OUT_DEPTH];
	logic [OPW-1:0]      owp_q, orp_q;
	logic [OCW-1:0]      ocnt_q, res_q;
	logic                opush, otake, take_res;

	assign take_res = q_valid && head.t_on;
	assign pop      = q_valid && (!head.t_on || (res_q < OCW'(OUT_DEPTH)));

	always_comb begin
		lword  = lhit1_q ? lbyp1_q : lrd;
		top    = d1_q.top_ok ? lword[15:0] : 16'd0;
		yv     = avg3(top, lword[31:16], d1_q.bot_ok ? d1_q.xv : 16'd0);
		lwe    = v1_q;
		lwdata = {d1_q.xv, lword[31:16]};
		pre    = v1_q && d1_q.s_on;

		pword  = phit2_q ? pbyp2_q : prd;
		midz   = pword[31:16];
		frnt   = d2_q.front_ok ? pword[15:0] : 16'd0;
		zv     = avg3(frnt, midz, d2_q.back_ok ? yv2_q : 16'd0);
		pwe    = v2_q && d2_q.s_on;
		pwdata = {yv2_q, midz};
		opush  = v2_q && d2_q.t_on;
	end

	bbl_ram #(.WIDTH(PAIR_W), .DEPTH(LINE_DEPTH)) u_line (
		.clk   (clk),
		.we    (lwe),
		.waddr (d1_q.laddr),
		.wdata (lwdata),
		.re    (pop),
		.raddr (head.laddr),
		.rdata (lrd)
	);

	bbl_ram #(.WIDTH(PAIR_W), .DEPTH(PLANE_DEPTH)) u_plane (
		.clk   (clk),
		.we    (pwe),
		.waddr (d2_q.paddr),
		.wdata (pwdata),
		.re    (pre),
		.raddr (d1_q.paddr),
		.rdata (prd)
	);

	always_ff @(posedge clk) begin
		d1_q    <= head;
		lhit1_q <= lwe && (head.laddr == d1_q.laddr);
		lbyp1_q <= lwdata;
		d2_q    <= d1_q;
		yv2_q   <= yv;
		phit2_q <= pwe && (d1_q.paddr == d2_q.paddr);
		pbyp2_q <= pwdata;
		if (opush) begin
			ofifo_q[owp_q] <= '{smoothed: zv, last: d2_q.last};
		end
	end

	assign results.valid    = ocnt_q != '0;
	assign results.smoothed = ofifo_q[orp_q].smoothed;
	assign results.last     = ofifo_q[orp_q].last;
	assign otake            = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
			res_q  <= '0;
		end else begin
			v1_q <= pop;
			v2_q <= v1_q;
			if (opush) begin
				owp_q <= owp_q + OPW'(1);
			end
			if (otake) begin
				orp_q <= orp_q + OPW'(1);
			end
			case ({opush, otake})
				2'b10:   ocnt_q <= ocnt_q + OCW'(1);
				2'b01:   ocnt_q <= ocnt_q - OCW'(1);
				default: ocnt_q <= ocnt_q;
			endcase
			case ({pop && take_res, otake})
				2'b10:   res_q <= res_q + OCW'(1);
				2'b01:   res_q <= res_q - OCW'(1);
				default: res_q <= res_q;
			endcase
		end
	end

	// reservations cover every result in flight or buffered
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_q <= OCW'(OUT_DEPTH))
		else $error("result reservations exceed buffer depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> (ocnt_q != OCW'(OUT_DEPTH)) || otake)
		else $error("result buffer overflow");

	a_cnt_le_res: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= res_q)
		else $error("buffered results exceed reservations");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |=> v2_q)
		else $error("back pipeline dropped an item");
endmodule

// File: design/box_blur_3d_separable.sv
// top level of the streaming separable 3x3x3 box blur
// usage:
//   samples (sink) takes one voxel or drain transaction per cycle when
//   valid and ready are high; voxels come in raster order, x fastest
//   results (source) delivers filtered voxels in the same raster order,
//   last marks the final voxel of the volume
//   an apb port holds size_x (0x0), size_y (0x4) and size_z (0x8); a
//   write to one of them restarts the stream; the user must make writes
//   only while idle, which the block does not enforce; the filtered voxel
//   at position t comes out after the input at position t + 1 + sx +
//   sx*sy is accepted; drain transactions push the tail of a volume out
//   throughput is one transaction per cycle unless results stalls, set by
//   the single line and plane ram ports, each read and written at most
//   once per item; after reset the sizes are 64 x 64 x 64 and both
//   positions are zero; the stores need no clearing pass
//   when results stalls, up to four results wait in the output buffer and
//   a four deep queue keeps taking samples until it fills
module box_blur_3d_separable (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [bbl_pkg::PAW-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	bbl_in_if.sink                 samples,
	bbl_out_if.source              results
);
	import bbl_pkg::*;

	logic [SW-1:0]  size_x_q, size_y_q;
	logic [SZW-1:0] size_z_q;
	logic           cfg_wr, restart;
	dims_t          dims;
	cfg_reg_t       reg_idx;

	// queue between front and back
	logic           q_push, q_full, q_pop, q_valid;
	desc_t          q_din, q_head;

	assign pready  = 1'b1;
	assign reg_idx = cfg_reg_t'(paddr[PAW-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	// register readback and restart on a write to a known register
	always_comb begin
		restart = 1'b0;
		prdata  = 32'd0;
		unique case (reg_idx)
			REG_SIZE_X: begin
				prdata  = {{(32-SW){1'b0}}, size_x_q};
				restart = cfg_wr;
			end
			REG_SIZE_Y: begin
				prdata  = {{(32-SW){1'b0}}, size_y_q};
				restart = cfg_wr;
			end
			REG_SIZE_Z: begin
				prdata  = {{(32-SZW){1'b0}}, size_z_q};
				restart = cfg_wr;
			end
			default: begin
				prdata  = 32'd0;
				restart = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SW'(64);
			size_y_q <= SW'(64);
			size_z_q <= SZW'(64);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SIZE_X: size_x_q <= pwdata[SW-1:0];
				REG_SIZE_Y: size_y_q <= pwdata[SW-1:0];
				REG_SIZE_Z: size_z_q <= pwdata[SZW-1:0];
				default:    size_x_q <= size_x_q;
			endcase
		end
	end

	// effective sizes: x and y clamped to the store extents, none below one
	always_comb begin
		if (size_x_q == '0) begin
			dims.cx = CXW'(1);
		end else if (32'(size_x_q) > MAX_SIZE_X) begin
			dims.cx = CXW'(MAX_SIZE_X);
		end else begin
			dims.cx = CXW'(size_x_q);
		end
		if (size_y_q == '0) begin
			dims.cy = CYW'(1);
		end else if (32'(size_y_q) > MAX_SIZE_Y) begin
			dims.cy = CYW'(MAX_SIZE_Y);
		end else begin
			dims.cy = CYW'(size_y_q);
		end
		dims.cz = (size_z_q == '0) ? SZW'(1) : size_z_q;
	end

	// front: positions, x pass and classification
	bbl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.dims    (dims),
		.samples (samples),
		.full    (q_full),
		.push    (q_push),
		.desc    (q_din)
	);

	bbl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.head   (q_head)
	);

	// back: y and z passes and the result buffer
	bbl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (q_head),
		.pop     (q_pop),
		.results (results)
	);
endmodule
